>>> src/gtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtp_pkg: shared types and constants of the go-to-point drive controller
// Formats, register indexes, the arctangent table and the front/back item.
// ----------------------------------------------------------------------------
package gtp_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned TabLen         = 24;

  localparam logic [2:0] REG_SPEED_LIMIT  = 3'd0;
  localparam logic [2:0] REG_TURN_GAIN    = 3'd1;
  localparam logic [2:0] REG_ANGLE_THRESH = 3'd2;
  localparam logic [2:0] REG_TURN_SAT     = 3'd3;
  localparam logic [2:0] REG_NEAR_DIST    = 3'd4;

  localparam logic signed [16:0] PiQ13    = 17'sd25736;
  localparam logic signed [16:0] TwoPiQ13 = 17'sd51472;
  localparam logic signed [35:0] HalfPiQ24 = 36'sd26353589;

  // Arctangent of 2^-i, Q.24, rounded to nearest.
  function automatic logic signed [35:0] atan_q24(input int unsigned i);
    logic signed [35:0] t;
    case (i)
      0: t = 36'sd13176795;  1: t = 36'sd7778716;  2: t = 36'sd4110060;
      3: t = 36'sd2086331;   4: t = 36'sd1047214;  5: t = 36'sd524117;
      6: t = 36'sd262123;    7: t = 36'sd131069;   8: t = 36'sd65536;
      9: t = 36'sd32768;    10: t = 36'sd16384;   11: t = 36'sd8192;
      12: t = 36'sd4096;    13: t = 36'sd2048;    14: t = 36'sd1024;
      15: t = 36'sd512;     16: t = 36'sd256;     17: t = 36'sd128;
      18: t = 36'sd64;      19: t = 36'sd32;      20: t = 36'sd16;
      21: t = 36'sd8;       22: t = 36'sd4;       default: t = 36'sd2;
    endcase
    return t;
  endfunction

  // Item from the front part to the back part.
  typedef struct packed {
    logic signed [16:0] err;       // wrapped heading error, Q3.13
    logic [23:0]        distance;  // saturated distance
  } gtp_item_t;

endpackage

>>> src/gtp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtp_front: offset, distance and heading error pipeline
// Forms the offset, squares it, runs a pipelined CORDIC and a pipelined
// restoring square root side by side, then wraps the heading error.
// ----------------------------------------------------------------------------
module gtp_front #(
  parameter int unsigned CORDIC_STEPS = gtp_pkg::CordicStepsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [23:0]  tx_i,
  input  logic signed [23:0]  ty_i,
  input  logic signed [23:0]  rx_i,
  input  logic signed [23:0]  ry_i,
  input  logic signed [15:0]  hdg_i,
  output logic                valid_o,
  output gtp_pkg::gtp_item_t  item_o
);
  import gtp_pkg::*;

  localparam int unsigned Steps = (CORDIC_STEPS > TabLen) ? TabLen : CORDIC_STEPS;
  // 25 sqrt bits cover a 50 bit radicand; two per stage.
  localparam int unsigned SqBits = 25;
  localparam int unsigned Lat = (Steps > SqBits) ? Steps : SqBits;

  // Index 0 is the offset and quadrant fold stage; the CORDIC and square
  // root stages follow, one stage each per cycle while en_i is high, and the
  // shorter chain is padded by carrying its result.
  logic signed [35:0] cx_q [Lat+1], cy_q [Lat+1], cz_q [Lat+1];
  logic [49:0]        rn_q [Lat+1];
  logic [49:0]        rr_q [Lat+1];
  logic signed [15:0] ch_q [Lat+1];
  logic               cz0_q [Lat+1];
  logic               cv_q [Lat+1];

  logic signed [24:0] dx, dy;
  logic signed [35:0] xs, ys;
  logic signed [49:0] px, py;
  logic [49:0]        sq;
  always_comb begin
    dx = 25'(tx_i) - 25'(rx_i);
    dy = 25'(ty_i) - 25'(ry_i);
    xs = 36'(dx) <<< 8;
    ys = 36'(dy) <<< 8;
    px = dx * dx;
    py = dy * dy;
    sq = px + py;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (en_i) begin
      cv_q[0] <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rn_q[0]  <= sq;
      rr_q[0]  <= '0;
      ch_q[0]  <= hdg_i;
      cz0_q[0] <= (dx == '0) && (dy == '0);
      if (xs < 0) begin
        if (ys >= 0) begin
          cx_q[0] <= ys; cy_q[0] <= -xs; cz_q[0] <= HalfPiQ24;
        end else begin
          cx_q[0] <= -ys; cy_q[0] <= xs; cz_q[0] <= -HalfPiQ24;
        end
      end else begin
        cx_q[0] <= xs; cy_q[0] <= ys; cz_q[0] <= '0;
      end
    end
  end

  for (genvar s = 0; s < Lat; s++) begin : g_stage
    logic signed [35:0] nx, ny, nz;
    logic [49:0]        nn, nr, bit_v;
    always_comb begin
      nx = cx_q[s]; ny = cy_q[s]; nz = cz_q[s];
      if (s < Steps) begin
        if (cy_q[s] > 0) begin
          nx = cx_q[s] + (cy_q[s] >>> s);
          ny = cy_q[s] - (cx_q[s] >>> s);
          nz = cz_q[s] + atan_q24(s);
        end else begin
          nx = cx_q[s] - (cy_q[s] >>> s);
          ny = cy_q[s] + (cx_q[s] >>> s);
          nz = cz_q[s] - atan_q24(s);
        end
      end
      nn = rn_q[s]; nr = rr_q[s];
      bit_v = '0;
      if (s < SqBits) begin
        bit_v = 50'd1 << (2 * (SqBits - 1 - s));
        if (rn_q[s] >= rr_q[s] + bit_v) begin
          nn = rn_q[s] - (rr_q[s] + bit_v);
          nr = (rr_q[s] >> 1) + bit_v;
        end else begin
          nr = rr_q[s] >> 1;
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[s+1] <= 1'b0;
      end else if (en_i) begin
        cv_q[s+1] <= cv_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cx_q[s+1] <= nx; cy_q[s+1] <= ny; cz_q[s+1] <= nz;
        rn_q[s+1] <= nn; rr_q[s+1] <= nr;
        ch_q[s+1] <= ch_q[s]; cz0_q[s+1] <= cz0_q[s];
      end
    end
  end

  // Final stage: round the angle, wrap, saturate the distance.
  logic signed [35:0] zr;
  logic signed [16:0] a, e;
  logic               v_q;
  gtp_item_t          item_q;
  always_comb begin
    zr = (cz_q[Lat] + 36'sd1024) >>> 11;
    a  = 17'(zr);
    e  = a - 17'(ch_q[Lat]);
    if (e > PiQ13) e = e - TwoPiQ13;
    else if (e < -PiQ13) e = e + TwoPiQ13;
    if (cz0_q[Lat]) e = '0;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= cv_q[Lat];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q.err      <= e;
      item_q.distance <= (rr_q[Lat] > 50'hFFFFFF) ? 24'hFFFFFF : rr_q[Lat][23:0];
    end
  end
  assign valid_o = v_q;
  assign item_o  = item_q;
endmodule

>>> src/gtp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtp_queue: short FIFO between the front and back parts
// Two-entry register FIFO with a fill count.
// ----------------------------------------------------------------------------
module gtp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  gtp_pkg::gtp_item_t data_i,
  input  logic               pop_i,
  output logic               valid_o,
  output gtp_pkg::gtp_item_t data_o,
  output logic [1:0]         count_o
);
  import gtp_pkg::*;

  gtp_item_t  mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rp_q];
  assign count_o = cnt_q;
endmodule

>>> src/gtp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtp_back: speed command stage
// Picks turn-only or drive mode, forms the gain products and clamps them.
// ----------------------------------------------------------------------------
module gtp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  gtp_pkg::gtp_item_t item_i,
  output logic               ready_o,
  input  logic [16:0]        speed_limit_i,
  input  logic [16:0]        turn_gain_i,
  input  logic [14:0]        angle_thresh_i,
  input  logic [14:0]        turn_sat_i,
  input  logic [23:0]        near_dist_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [16:0]        fwd_o,
  output logic signed [17:0] turn_o,
  output logic [23:0]        dist_o,
  output logic signed [15:0] err_o
);
  import gtp_pkg::*;

  // Stage 1: products registered.
  logic               v1_q;
  logic signed [35:0] tprod_q;
  logic [40:0]        fprod_q;
  gtp_item_t          it1_q;
  logic [16:0]        sl1_q, tg1_q;
  logic [14:0]        th1_q, ts1_q;
  logic [23:0]        nd1_q;
  logic               v2_q;
  logic               adv1, adv2;

  assign adv2    = !v2_q || ready_i;
  assign adv1    = !v1_q || adv2;
  assign ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv1 && valid_i) begin
      tprod_q <= $signed({1'b0, turn_gain_i}) * item_i.err;
      fprod_q <= speed_limit_i * item_i.distance;
      it1_q <= item_i;
      sl1_q <= speed_limit_i; tg1_q <= turn_gain_i;
      th1_q <= angle_thresh_i; ts1_q <= turn_sat_i; nd1_q <= near_dist_i;
    end
  end

  // Stage 2: mode select, rounding and clamps.
  logic signed [16:0] ae;
  logic signed [35:0] tr, turn;
  logic [40:0]        fr;
  logic [41:0]        fwd;
  always_comb begin
    ae   = it1_q.err < 0 ? -it1_q.err : it1_q.err;
    tr   = (tprod_q + 36'sd4096) >>> 13;
    fr   = (fprod_q + 41'd32768) >> 16;
    turn = tr;
    if (ae > $signed({2'b0, th1_q})) begin
      fwd = '0;
      if (ae >= $signed({2'b0, ts1_q}))
        turn = it1_q.err < 0 ? -36'(sl1_q & 17'h0) - 36'(tg1_q) : 36'(tg1_q);
    end else if (it1_q.distance >= nd1_q) begin
      fwd = 42'(sl1_q);
    end else begin
      fwd = 42'(fr);
    end
    if (turn > 36'sd65536) turn = 36'sd65536;
    else if (turn < -36'sd65536) turn = -36'sd65536;
    if (fwd > 42'd65536) fwd = 42'd65536;
  end
  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      fwd_o  <= fwd[16:0];
      turn_o <= turn[17:0];
      dist_o <= it1_q.distance;
      err_o  <= it1_q.err[15:0];
    end
  end
  assign valid_o = v2_q;
endmodule

>>> src/go_to_point_drive_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_point_drive_controller_core: go-to-goal speed controller
// Distance and heading error to a target, turned into drive speeds.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  s_axis   in         tvalid/tready       target and pose
//  m_axis   out        tvalid/tready       speeds, distance, error
//  cfg      in         cfg_valid/cfg_ready register index and value
// One item per cycle when no part stalls; most of the path is the CORDIC
// and square root pipeline in the front part.
// Reset loads the register defaults and empties all stages. The front
// pipeline stalls while the queue holds a beat that the back part does not
// take and either the front part has a result ready or the queue is full;
// the back part stalls on m_axis_tready.
module go_to_point_drive_controller_core #(
  parameter int unsigned CORDIC_STEPS = gtp_pkg::CordicStepsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // target_x[23:0], target_y[47:24], robot_x[71:48], robot_y[95:72],
  // robot_heading[111:96]
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // fwd_speed[16:0], turn_speed[34:17], distance[58:35], heading_error[74:59]
  output logic [79:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [23:0]  cfg_data_i
);
  import gtp_pkg::*;

  logic [16:0] speed_limit_q, turn_gain_q;
  logic [14:0] angle_thresh_q, turn_sat_q;
  logic [23:0] near_dist_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_limit_q <= 17'd32768; turn_gain_q <= 17'd32768;
      angle_thresh_q <= 15'd164; turn_sat_q <= 15'd8192;
      near_dist_q <= 24'd6554;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SPEED_LIMIT:  speed_limit_q  <= cfg_data_i[16:0];
        REG_TURN_GAIN:    turn_gain_q    <= cfg_data_i[16:0];
        REG_ANGLE_THRESH: angle_thresh_q <= cfg_data_i[14:0];
        REG_TURN_SAT:     turn_sat_q     <= cfg_data_i[14:0];
        REG_NEAR_DIST:    near_dist_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic      fv, qv, qpop, bready, en;
  gtp_item_t fitem, qitem;
  logic [1:0] qcnt;

  // The front part advances only when the queue can take what leaves it.
  assign en = (qcnt == 2'd0) || qpop || (qcnt == 2'd1 && !fv);
  assign s_axis_tready = en;
  assign qpop = qv && bready;

  gtp_front #(.CORDIC_STEPS(CORDIC_STEPS)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid),
    .tx_i(s_axis_tdata[23:0]), .ty_i(s_axis_tdata[47:24]),
    .rx_i(s_axis_tdata[71:48]), .ry_i(s_axis_tdata[95:72]),
    .hdg_i(s_axis_tdata[111:96]), .valid_o(fv), .item_o(fitem)
  );

  gtp_queue u_queue (
    .clk_i, .rst_ni, .push_i(fv && en), .data_i(fitem), .pop_i(qpop),
    .valid_o(qv), .data_o(qitem), .count_o(qcnt)
  );

  logic [16:0]        fwd;
  logic signed [17:0] turn;
  logic [23:0]        distance;
  logic signed [15:0] err;

  gtp_back u_back (
    .clk_i, .rst_ni, .valid_i(qv), .item_i(qitem), .ready_o(bready),
    .speed_limit_i(speed_limit_q), .turn_gain_i(turn_gain_q),
    .angle_thresh_i(angle_thresh_q), .turn_sat_i(turn_sat_q),
    .near_dist_i(near_dist_q), .valid_o(m_axis_tvalid), .ready_i(m_axis_tready),
    .fwd_o(fwd), .turn_o(turn), .dist_o(distance), .err_o(err)
  );

  assign m_axis_tdata = {5'b0, err, distance, turn, fwd};
endmodule
